### src/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned BASE_W = 6;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CHAR_W-1:0] ASCII_ZERO        = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_LETTER_BIAS = 8'd55;
  localparam logic [CHAR_W-1:0] LOWER_CASE_OFFSET = 8'd32;
  localparam logic [CHAR_W-1:0] CHAR_NINE         = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A      = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z      = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A      = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z      = 8'h7A;
  localparam logic [CHAR_W-1:0] MINUS_CHAR        = 8'h2D;
  localparam logic [CHAR_W-1:0] NUL_CHAR          = 8'h00;
  localparam logic [BASE_W-1:0] MIN_BASE          = 6'd2;
  localparam logic [BASE_W-1:0] MAX_BASE          = 6'd36;
  localparam logic [BASE_W-1:0] MAX_DECIMAL_DIGIT = 6'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_BASE   = 2'd1;

  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 6'd10;
  localparam logic [BASE_W-1:0] DEST_BASE_RST   = 6'd10;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_BASE    = 3'd1,
    ST_BAD_CHAR    = 3'd2,
    ST_NOT_IN_BASE = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    KIND_SIGN,
    KIND_DIGIT,
    KIND_BAD_CHAR
  } kind_e;

  typedef enum logic [2:0] {
    BK_ACCUM,
    BK_DIV,
    BK_SIGN,
    BK_RDREQ,
    BK_EMIT,
    BK_ERR
  } back_state_e;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              in_last;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              out_last;
    status_e           status;
  } out_item_t;

  // A character after classification, as it travels from front to back.
  typedef struct packed {
    kind_e             kind;
    logic              last;
    logic              base_bad;
    logic              not_in_base;
    logic [BASE_W-1:0] digit;
    logic [BASE_W-1:0] base;
  } cls_item_t;

  function automatic logic base_ok(input logic [BASE_W-1:0] b);
    return (b >= MIN_BASE) && (b <= MAX_BASE);
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] wide;
    wide = {{(CHAR_W-BASE_W){1'b0}}, d};
    return (d <= MAX_DECIMAL_DIGIT) ? wide + ASCII_ZERO : wide + ASCII_LETTER_BIAS;
  endfunction

endpackage

`default_nettype wire

### src/rsc_ram.sv
`default_nettype none

module rsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### src/rsc_front.sv
`default_nettype none

module rsc_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire rsc_pkg::in_item_t          in_data_i,
  input  wire logic [rsc_pkg::BASE_W-1:0] source_base_i,
  input  wire logic                       full_i,
  output logic                            push_o,
  output rsc_pkg::cls_item_t              push_data_o
);

  import rsc_pkg::*;

  logic              at_first_q, at_first_d;
  logic [CHAR_W-1:0] c;
  logic [CHAR_W-1:0] dval;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign c          = in_data_i.in_char;

  always_comb begin
    dval = NUL_CHAR;
    push_data_o.kind = KIND_BAD_CHAR;
    if (at_first_q && (c == MINUS_CHAR)) begin
      push_data_o.kind = KIND_SIGN;
    end else if ((c >= ASCII_ZERO) && (c <= CHAR_NINE)) begin
      push_data_o.kind = KIND_DIGIT;
      dval = c - ASCII_ZERO;
    end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) begin
      push_data_o.kind = KIND_DIGIT;
      dval = c - ASCII_LETTER_BIAS;
    end else if ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) begin
      push_data_o.kind = KIND_DIGIT;
      dval = c - LOWER_CASE_OFFSET - ASCII_LETTER_BIAS;
    end
    push_data_o.last        = in_data_i.in_last;
    push_data_o.base_bad    = !base_ok(source_base_i);
    push_data_o.digit       = dval[BASE_W-1:0];
    push_data_o.not_in_base = dval[BASE_W-1:0] >= source_base_i;
    push_data_o.base        = source_base_i;
  end

  // A minus sign counts only as the first character of a number.
  always_comb begin
    at_first_d = at_first_q;
    if (push_o) begin
      at_first_d = in_data_i.in_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_first_q <= 1'b1;
    end else begin
      at_first_q <= at_first_d;
    end
  end

endmodule

`default_nettype wire

### src/rsc_queue.sv
`default_nettype none

module rsc_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire rsc_pkg::cls_item_t push_data_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output rsc_pkg::cls_item_t      pop_data_o
);

  import rsc_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  cls_item_t          entry_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     count_q, count_d;

  assign full_o     = count_q == (PTR_W+1)'(DEPTH);
  assign valid_o    = count_q != '0;
  assign pop_data_o = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### src/rsc_back.sv
`default_nettype none

module rsc_back #(
  parameter int unsigned VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       item_valid_i,
  input  wire rsc_pkg::cls_item_t         item_i,
  output logic                            pop_o,
  input  wire logic [rsc_pkg::BASE_W-1:0] dest_base_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output rsc_pkg::out_item_t              out_data_o
);

  import rsc_pkg::*;

  localparam int unsigned MAG_W  = VALUE_BITS - 1;
  localparam int unsigned STEP_W = $clog2(MAG_W);
  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);
  localparam int unsigned CNT_W  = ADDR_W + 1;
  localparam int unsigned ACC_W  = MAG_W + BASE_W + 1;

  back_state_e        state_q, state_d;
  logic [MAG_W-1:0]   mag_q, mag_d;
  logic               neg_q, neg_d;
  status_e            err_q, err_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic [MAG_W-1:0]   quot_q, quot_d;
  logic [BASE_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0]  step_q, step_d;

  logic [MAG_W-1:0]   mag_a;
  logic               neg_a;
  status_e            err_a, err_f;
  logic [ACC_W-1:0]   acc;

  logic [BASE_W:0]    rem_shift;
  logic               rem_ge;
  logic [BASE_W:0]    rem_sub;
  logic [BASE_W-1:0]  rem_n;
  logic [MAG_W-1:0]   quot_n;

  logic               slot_free;
  logic               load;
  logic               ram_we, ram_re;
  logic [BASE_W-1:0]  ram_rdata;
  logic [CNT_W-1:0]   cnt_dec;

  function automatic status_e merge_err(input status_e cur, input status_e code);
    return ((cur == ST_OK) || (code < cur)) ? code : cur;
  endfunction

  assign pop_o     = item_valid_i && (state_q == BK_ACCUM);
  assign slot_free = !out_valid_q || out_ready_i;
  assign cnt_dec   = cnt_q - 1'b1;

  // Accumulation of one classified character.
  always_comb begin
    acc   = ({{(BASE_W+1){1'b0}}, mag_q} * ACC_W'(item_i.base)) + ACC_W'(item_i.digit);
    mag_a = mag_q;
    neg_a = neg_q;
    err_a = err_q;
    if (item_i.base_bad) begin
      err_a = merge_err(err_a, ST_BAD_BASE);
    end
    case (item_i.kind)
      KIND_SIGN: begin
        neg_a = 1'b1;
      end
      KIND_DIGIT: begin
        if (err_a == ST_OK) begin
          if (item_i.not_in_base) begin
            err_a = ST_NOT_IN_BASE;
          end else if (|acc[ACC_W-1:MAG_W]) begin
            err_a = ST_OVERFLOW;
          end else begin
            mag_a = acc[MAG_W-1:0];
          end
        end
      end
      default: begin
        err_a = merge_err(err_a, ST_BAD_CHAR);
      end
    endcase
    err_f = err_a;
    if ((err_a == ST_OK) && !base_ok(dest_base_i)) begin
      err_f = ST_BAD_BASE;
    end
  end

  // One quotient bit per cycle; the remainder always stays below the base.
  always_comb begin
    rem_shift = {rem_q, quot_q[MAG_W-1]};
    rem_ge    = rem_shift >= {1'b0, dest_base_i};
    rem_sub   = rem_shift - {1'b0, dest_base_i};
    rem_n     = rem_ge ? rem_sub[BASE_W-1:0] : rem_shift[BASE_W-1:0];
    quot_n    = {quot_q[MAG_W-2:0], rem_ge};
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_ACCUM: begin
        if (pop_o && item_i.last) begin
          state_d = (err_f != ST_OK) ? BK_ERR : BK_DIV;
        end
      end
      BK_DIV: begin
        if ((step_q == '0) && (quot_n == '0)) begin
          state_d = (neg_q && (mag_q != '0)) ? BK_SIGN : BK_RDREQ;
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          state_d = BK_RDREQ;
        end
      end
      BK_RDREQ: begin
        state_d = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          state_d = (cnt_q == CNT_W'(1)) ? BK_ACCUM : BK_RDREQ;
        end
      end
      BK_ERR: begin
        if (slot_free) begin
          state_d = BK_ACCUM;
        end
      end
      default: begin
        state_d = BK_ACCUM;
      end
    endcase
  end

  always_comb begin
    mag_d  = mag_q;
    neg_d  = neg_q;
    err_d  = err_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    step_d = step_q;
    out_d  = out_q;
    load   = 1'b0;
    ram_we = 1'b0;
    ram_re = 1'b0;
    case (state_q)
      BK_ACCUM: begin
        if (pop_o) begin
          mag_d = mag_a;
          neg_d = neg_a;
          err_d = err_a;
          if (item_i.last) begin
            err_d  = err_f;
            quot_d = mag_a;
            rem_d  = '0;
            step_d = STEP_W'(MAG_W - 1);
            cnt_d  = '0;
          end
        end
      end
      BK_DIV: begin
        quot_d = quot_n;
        rem_d  = rem_n;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          ram_we = 1'b1;
          cnt_d  = cnt_q + 1'b1;
          rem_d  = '0;
          step_d = STEP_W'(MAG_W - 1);
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          load  = 1'b1;
          out_d = '{out_char: MINUS_CHAR, out_last: 1'b0, status: ST_OK};
        end
      end
      BK_RDREQ: begin
        ram_re = 1'b1;
      end
      BK_EMIT: begin
        if (slot_free) begin
          load  = 1'b1;
          out_d = '{out_char: digit_char(ram_rdata), out_last: cnt_q == CNT_W'(1),
                    status: ST_OK};
          cnt_d = cnt_dec;
          if (cnt_q == CNT_W'(1)) begin
            mag_d = '0;
            neg_d = 1'b0;
            err_d = ST_OK;
          end
        end
      end
      BK_ERR: begin
        if (slot_free) begin
          load  = 1'b1;
          out_d = '{out_char: NUL_CHAR, out_last: 1'b1, status: err_q};
          mag_d = '0;
          neg_d = 1'b0;
          err_d = ST_OK;
        end
      end
      default: begin
        load = 1'b0;
      end
    endcase
    out_valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  rsc_ram #(
    .WIDTH (BASE_W),
    .DEPTH (VALUE_BITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i (rem_n),
    .re_i    (ram_re),
    .raddr_i (cnt_dec[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_ACCUM;
      mag_q       <= '0;
      neg_q       <= 1'b0;
      err_q       <= ST_OK;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mag_q       <= mag_d;
      neg_q       <= neg_d;
      err_q       <= err_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    step_q <= step_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAG_W))
    else $error("digit count exceeds the magnitude width");

  a_emit_has_digit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == BK_RDREQ) || (state_q == BK_EMIT)) |-> (cnt_q != '0))
    else $error("digit emission with no digit stored");

  a_rem_below_base : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DIV) |-> (rem_q < dest_base_i))
    else $error("division remainder not below the destination base");

  a_err_state_code : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_ERR) |-> (err_q != ST_OK))
    else $error("error transaction without an error code");

  a_div_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != BK_DIV) && (state_d == BK_DIV)) |=> (cnt_q == '0))
    else $error("conversion started with a stale digit count");

endmodule

`default_nettype wire

### src/radix_string_converter_top.sv
// Converts a signed number given as text in source_base to text in dest_base (both 2..36).
// Characters enter one per transaction with in_last on the final one; each is classified on
// entry and queued, then accumulated by a combinational 31x6 multiply-add. After the last
// character the magnitude is divided repeatedly by dest_base in a bit-serial divider,
// digits are parked in a small RAM, and are then sent most significant first, each read
// from the RAM (BK_RDREQ) before it is sent (BK_EMIT), preceded by '-' for a negative value.
// Zero is sent as "0". Any error gives a single transaction with out_char zero, out_last set
// and the error code in status. The input keeps accepting characters of the next number while
// a conversion is in progress, until the two-entry queue fills. Registers are written through
// the configuration channel (index 0 source_base, index 1 dest_base, other indices ignored).
`default_nettype none

module radix_string_converter_top #(
  parameter int unsigned VALUE_BITS = rsc_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire rsc_pkg::in_item_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output rsc_pkg::out_item_t                 out_data_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [rsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [rsc_pkg::BASE_W-1:0]    cfg_data_i
);

  import rsc_pkg::*;

  logic [BASE_W-1:0] source_base_q, source_base_d;
  logic [BASE_W-1:0] dest_base_q, dest_base_d;
  logic              push, full, pop, item_valid;
  cls_item_t         push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    source_base_d = source_base_q;
    dest_base_d   = dest_base_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SOURCE_BASE: source_base_d = cfg_data_i;
        CFG_DEST_BASE:   dest_base_d   = cfg_data_i;
        default: begin
          source_base_d = source_base_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_base_q <= SOURCE_BASE_RST;
      dest_base_q   <= DEST_BASE_RST;
    end else begin
      source_base_q <= source_base_d;
      dest_base_q   <= dest_base_d;
    end
  end

  rsc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_data_i     (in_data_i),
    .source_base_i (source_base_q),
    .full_i        (full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  rsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (item_valid),
    .pop_data_o  (pop_data)
  );

  rsc_back #(
    .VALUE_BITS (VALUE_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (pop_data),
    .pop_o        (pop),
    .dest_base_i  (dest_base_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

### tb/rsc_checker.sv
`timescale 1ns / 1ps

module rsc_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  rsc_pkg::in_item_t             in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  rsc_pkg::out_item_t            out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [rsc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rsc_pkg::BASE_W-1:0]    cfg_data_i,
  output int unsigned                   fail_count_o,
  output int unsigned                   pending_o
);

  import rsc_pkg::*;

  localparam longint unsigned MAG_MAX = (64'd1 << (VALUE_BITS_DEF - 1)) - 64'd1;

  logic [BASE_W-1:0] src_base;
  logic [BASE_W-1:0] dst_base;
  longint unsigned   mag;
  logic              minus_seen;
  logic              at_head;
  status_e           fault;
  out_item_t         chars_due[$];
  int unsigned       mismatches;

  function automatic int char_value(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] up;
    up = (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ? c - LOWER_CASE_OFFSET : c;
    if (c >= ASCII_ZERO && c <= CHAR_NINE) return int'(c - ASCII_ZERO);
    if (up >= CHAR_UPPER_A && up <= CHAR_UPPER_Z) return int'(up - ASCII_LETTER_BIAS);
    return -1;
  endfunction

  // The lowest non-zero code seen so far is the one reported.
  function automatic void raise_fault(input status_e code);
    if (fault == ST_OK || code < fault) fault = code;
  endfunction

  task automatic absorb_char(input in_item_t it);
    logic              head;
    int                dv;
    longint unsigned   rest;
    logic [BASE_W-1:0] digs[VALUE_BITS_DEF];
    int                n;
    out_item_t         r;
    head = at_head;
    at_head = 1'b0;
    if (!(src_base >= MIN_BASE && src_base <= MAX_BASE)) raise_fault(ST_BAD_BASE);
    if (head && it.in_char == MINUS_CHAR) begin
      minus_seen = 1'b1;
    end else begin
      dv = char_value(it.in_char);
      if (dv < 0) begin
        raise_fault(ST_BAD_CHAR);
      end else if (fault == ST_OK) begin
        if (64'(dv) >= 64'(src_base)) begin
          raise_fault(ST_NOT_IN_BASE);
        end else if (mag > (MAG_MAX - 64'(dv)) / 64'(src_base)) begin
          raise_fault(ST_OVERFLOW);
        end else begin
          mag = mag * 64'(src_base) + 64'(dv);
        end
      end
    end
    if (!it.in_last) return;

    if (fault == ST_OK && !(dst_base >= MIN_BASE && dst_base <= MAX_BASE)) begin
      raise_fault(ST_BAD_BASE);
    end
    if (fault != ST_OK) begin
      r.out_char = NUL_CHAR;
      r.out_last = 1'b1;
      r.status   = fault;
      chars_due.push_back(r);
    end else begin
      rest = mag;
      n = 0;
      do begin
        digs[n] = BASE_W'(rest % 64'(dst_base));
        n++;
        rest = rest / 64'(dst_base);
      end while (rest != 0);
      // A zero value never carries a sign.
      if (minus_seen && mag != 0) begin
        r.out_char = MINUS_CHAR;
        r.out_last = 1'b0;
        r.status   = ST_OK;
        chars_due.push_back(r);
      end
      for (int k = n - 1; k >= 0; k--) begin
        r.out_char = (digs[k] <= MAX_DECIMAL_DIGIT) ? CHAR_W'(digs[k]) + ASCII_ZERO
                                                    : CHAR_W'(digs[k]) + ASCII_LETTER_BIAS;
        r.out_last = (k == 0);
        r.status   = ST_OK;
        chars_due.push_back(r);
      end
    end
    mag        = 0;
    minus_seen = 1'b0;
    at_head    = 1'b1;
    fault      = ST_OK;
  endtask

  task automatic check_char(input out_item_t got);
    out_item_t want;
    if (chars_due.size() == 0) begin
      $error("unexpected transaction: out_char %h out_last %b status %0d",
             got.out_char, got.out_last, got.status);
      mismatches++;
      return;
    end
    want = chars_due.pop_front();
    if (got.out_char !== want.out_char) begin
      $error("out_char: expected %h, got %h", want.out_char, got.out_char);
      mismatches++;
    end
    if (got.out_last !== want.out_last) begin
      $error("out_last: expected %b, got %b", want.out_last, got.out_last);
      mismatches++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base   = SOURCE_BASE_RST;
      dst_base   = DEST_BASE_RST;
      mag        = 0;
      minus_seen = 1'b0;
      at_head    = 1'b1;
      fault      = ST_OK;
      mismatches = 0;
      chars_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_SOURCE_BASE) src_base = cfg_data_i;
        else if (cfg_index_i == CFG_DEST_BASE) dst_base = cfg_data_i;
      end
      // An output transaction can never stem from an input taken at the same edge.
      if (out_valid_i && out_ready_i) check_char(out_data_i);
      if (in_valid_i && in_ready_i) absorb_char(in_data_i);
      fail_count_o <= mismatches;
      pending_o    <= chars_due.size();
    end
  end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import rsc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 5000000;
  localparam int unsigned DRAIN_CYCLES = 1200;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam longint unsigned MAG_MAX  = (64'd1 << (VALUE_BITS_DEF - 1)) - 64'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SOURCE_BASE;
  logic [BASE_W-1:0]    cfg_data = SOURCE_BASE_RST;

  int unsigned fails;
  int unsigned pending;
  int unsigned cycles = 0;
  int unsigned idle_pct = 15;
  bit          hold_req = 1'b0;
  in_item_t    stim_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  radix_string_converter_top uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  rsc_checker conv_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("radix_string_converter_top regression: fail");
    $finish;
  end

  // Receiver side: random back-pressure, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) stim_q.push_back('{s[i], (i == s.len() - 1)});
  endfunction

  function automatic void queue_number(input int unsigned radix);
    logic [CHAR_W-1:0] txt[$];
    longint unsigned   val;
    int unsigned       width;
    int unsigned       d;
    int unsigned       pos;
    int unsigned       spare;
    width = $urandom_range(33, 0);
    val = {$urandom, $urandom};
    val = (width == 0) ? 64'd0 : val & ((64'd1 << width) - 64'd1);
    if ($urandom_range(19) == 0) val = MAG_MAX + $urandom_range(1);
    do begin
      d = 32'(val % radix);
      if (d <= MAX_DECIMAL_DIGIT) txt.push_front(ASCII_ZERO + CHAR_W'(d));
      else if ($urandom_range(1)) txt.push_front(ASCII_LETTER_BIAS + CHAR_W'(d) + LOWER_CASE_OFFSET);
      else txt.push_front(ASCII_LETTER_BIAS + CHAR_W'(d));
      val = val / radix;
    end while (val != 0);
    if ($urandom_range(7) == 0) txt.push_front(ASCII_ZERO);
    if ($urandom_range(1)) txt.push_front(MINUS_CHAR);
    // Roughly one number in seven is spoilt somewhere along its text.
    if ($urandom_range(6) == 0) begin
      pos = $urandom_range(txt.size() - 1);
      case ($urandom_range(2))
        0: txt[pos] = CHAR_W'($urandom_range(255));
        1: txt[pos] = MINUS_CHAR;
        default: begin
          if (radix < MAX_BASE) begin
            spare = $urandom_range(MAX_BASE - 1, radix);
            txt[pos] = (spare <= MAX_DECIMAL_DIGIT) ? ASCII_ZERO + CHAR_W'(spare)
                                                    : ASCII_LETTER_BIAS + CHAR_W'(spare);
          end
        end
      endcase
    end
    foreach (txt[i]) stim_q.push_back('{txt[i], (i == txt.size() - 1)});
  endfunction

  task automatic push_char(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_all();
    foreach (stim_q[i]) push_char(stim_q[i]);
    in_valid <= 1'b0;
  endtask

  // The pending count is registered and lags the edge, hence the leading edge.
  task automatic settle();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_bases(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] dst);
    cfg_valid <= 1'b1;
    cfg_index <= $urandom_range(1) ? CFG_SPARE_LO : CFG_SPARE_HI;
    cfg_data  <= BASE_W'($urandom);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_SOURCE_BASE;
    cfg_data  <= src;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_DEST_BASE;
    cfg_data  <= dst;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [BASE_W-1:0] src, input logic [BASE_W-1:0] dst,
                           input int unsigned quota, input bit calm, input bit hold);
    int unsigned radix;
    settle();
    set_bases(src, dst);
    radix = (src >= MIN_BASE && src <= MAX_BASE) ? 32'(src) : 32'(SOURCE_BASE_RST);
    stim_q = {};
    while (stim_q.size() < quota) queue_number(radix);
    idle_pct = calm ? 0 : 15;
    hold_req = hold;
    send_all();
    idle_pct = 15;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Short directed run on the reset bases.
    stim_q = {};
    queue_text("-");
    queue_text("-0");
    queue_text("0");
    queue_text("9");
    stim_q.push_back('{NUL_CHAR, 1'b1});
    stim_q.push_back('{8'hFF, 1'b1});
    queue_text("Az");
    queue_text("1-2");
    queue_text("-2147483648");
    send_all();

    run_phase(MIN_BASE, MAX_BASE, 45, 1'b0, 1'b0);
    run_phase(MAX_BASE, MIN_BASE, 45, 1'b0, 1'b1);
    run_phase(6'd16, 6'd10, 45, 1'b1, 1'b0);
    run_phase(6'd10, 6'd16, 45, 1'b0, 1'b0);
    run_phase(6'd0, 6'd10, 20, 1'b0, 1'b0);
    run_phase(6'd10, 6'd1, 20, 1'b0, 1'b0);
    run_phase(6'd37, MAX_BASE, 20, 1'b0, 1'b0);
    run_phase(6'd63, 6'd63, 15, 1'b0, 1'b0);
    repeat (4) begin
      run_phase(BASE_W'($urandom_range(MAX_BASE, MIN_BASE)),
                BASE_W'($urandom_range(MAX_BASE, MIN_BASE)), 45, 1'b0, 1'b0);
    end

    settle();
    if (fails == 0) begin
      $display("radix_string_converter_top regression: pass");
    end else begin
      $display("radix_string_converter_top regression: fail");
    end
    $finish;
  end

endmodule

### files.f
src/rsc_pkg.sv
src/rsc_ram.sv
src/rsc_front.sv
src/rsc_queue.sv
src/rsc_back.sv
src/radix_string_converter_top.sv
tb/rsc_checker.sv
tb/tb.sv
